FILE: hdl/ffua_pkg.sv
`default_nettype none
package ffua_pkg;

    localparam int TIME_W = 32;
    localparam int IDX_W  = 6;
    localparam int UNIT_W = 5;

    // operation codes
    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_SET     = 2'd2;
    localparam logic [1:0] OP_READ    = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_MEAN  = 2'd0;
    localparam logic [1:0] CFG_COUNT = 2'd1;

    // command transfer
    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] quantity;
        logic [IDX_W-1:0]  unit_index;
        logic [TIME_W-1:0] time_value;
    } t_cmd;

    // result transfer
    typedef struct packed {
        logic [1:0]        status;
        logic [UNIT_W-1:0] unit;
        logic [TIME_W-1:0] time_out;
    } t_rsp;

    // operation travelling down the cell chain
    typedef struct packed {
        logic              vld;
        logic [1:0]        op;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] end_time;
        logic [IDX_W-1:0]  idx;
        logic [TIME_W-1:0] tval;
        logic              found;
        logic [UNIT_W-1:0] unit;
        logic [TIME_W-1:0] tout;
    } t_token;

endpackage
`default_nettype wire

FILE: hdl/ffua_front.sv
`default_nettype none
module ffua_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire ffua_pkg::t_cmd              i_cmd,
    input  wire logic [ffua_pkg::TIME_W-1:0] i_mean,
    output ffua_pkg::t_token                 o_tok
);
    import ffua_pkg::*;

    localparam int PROD_W = 2 * TIME_W;
    localparam int SUM_W  = PROD_W - 16 + 1;

    logic                r_vld;
    logic [1:0]          r_op;
    logic [TIME_W-1:0]   r_now;
    logic [IDX_W-1:0]    r_idx;
    logic [TIME_W-1:0]   r_tval;
    logic [PROD_W-1:0]   r_prod;
    logic [PROD_W-1:0]   n_prod;
    logic [SUM_W-1:0]    w_sum;
    logic [TIME_W-1:0]   w_end;
    t_token              r_tok;
    t_token              n_tok;

    // stage one: service time product
    assign n_prod = PROD_W'(i_mean) * PROD_W'(i_cmd.quantity);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_load;
        end
        if (i_load) begin
            r_op   <= i_cmd.opcode;
            r_now  <= i_cmd.now;
            r_idx  <= i_cmd.unit_index;
            r_tval <= i_cmd.time_value;
            r_prod <= n_prod;
        end
    end

    // stage two: drop fraction, add now, saturate
    assign w_sum = SUM_W'(r_prod[PROD_W-1:16]) + SUM_W'(r_now);
    assign w_end = (|w_sum[SUM_W-1:TIME_W]) ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];

    always_comb begin
        n_tok          = '0;
        n_tok.vld      = r_vld;
        n_tok.op       = r_op;
        n_tok.now      = r_now;
        n_tok.end_time = w_end;
        n_tok.idx      = r_idx;
        n_tok.tval     = r_tval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.vld <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

FILE: hdl/ffua_cell.sv
`default_nettype none
module ffua_cell #(
    parameter int CELL_ID = 0
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [ffua_pkg::IDX_W-1:0] i_count,
    input  wire ffua_pkg::t_token           i_tok,
    output ffua_pkg::t_token                o_tok
);
    import ffua_pkg::*;

    localparam logic [IDX_W:0] ID_X = (IDX_W+1)'(CELL_ID);

    logic [TIME_W-1:0] r_busy;
    logic [TIME_W-1:0] n_busy;
    t_token            r_tok;
    t_token            n_tok;
    logic              w_hit;
    logic              w_scan;

    assign w_hit  = i_tok.idx == ID_X[IDX_W-1:0];
    assign w_scan = {1'b0, i_count} > ID_X;

    // act on this cell's busy-until time
    always_comb begin
        n_busy = r_busy;
        n_tok  = i_tok;
        if (i_tok.vld) begin
            case (i_tok.op)
                OP_ALLOC: begin
                    if (!i_tok.found && w_scan && r_busy <= i_tok.now) begin
                        n_busy      = i_tok.end_time;
                        n_tok.found = 1'b1;
                        n_tok.unit  = ID_X[UNIT_W-1:0];
                        n_tok.tout  = i_tok.end_time;
                    end
                end
                OP_RELEASE: begin
                    if (w_hit) begin
                        n_busy = '0;
                    end
                end
                OP_SET: begin
                    if (w_hit) begin
                        n_busy = i_tok.tval;
                    end
                end
                OP_READ: begin
                    if (w_hit) begin
                        n_tok.tout = r_busy;
                    end
                end
                default: begin
                    n_busy = r_busy;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= '0;
            r_tok.vld <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_tok  <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

FILE: hdl/first_free_unit_allocator.sv
// channel   | direction | handshake                        | payload
// ----------+-----------+----------------------------------+------------------------------
// command   | in        | start & !busy                    | i_cmd (t_cmd)
// result    | out       | o_done, one cycle, no stall      | o_rsp (t_rsp)
// config    | in        | i_cfg_valid & o_cfg_ready        | i_cfg_index, i_cfg_data
//
// every command passes through the end-time multiply and add registers, a
// register in each unit cell as the operation walks the chain, and the
// result register. busy stays high from the transfer until o_done; the next
// command is taken in the cycle o_done is shown. register writes are held
// off while busy is high. reset clears all busy-until times at once; the
// result receiver cannot stall the block.
`default_nettype none
module first_free_unit_allocator #(
    parameter int UNITS = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire ffua_pkg::t_cmd              i_cmd,
    output logic                             o_done,
    output ffua_pkg::t_rsp                   o_rsp,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [1:0]                  i_cfg_index,
    input  wire logic [ffua_pkg::TIME_W-1:0] i_cfg_data
);
    import ffua_pkg::*;

    localparam logic [IDX_W:0] UNITS_X = (IDX_W+1)'(UNITS);

    logic              r_busy;
    logic              r_done;
    t_rsp              r_rsp;
    t_rsp              n_rsp;
    logic [TIME_W-1:0] r_mean;
    logic [IDX_W-1:0]  r_count;
    logic              w_load;
    t_token            w_tok [0:UNITS];
    t_token            w_last;

    assign w_load      = start && !r_busy;
    assign busy        = r_busy;
    assign o_cfg_ready = !r_busy;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean  <= '0;
            r_count <= IDX_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MEAN:  r_mean  <= i_cfg_data;
                CFG_COUNT: r_count <= i_cfg_data[IDX_W-1:0];
                default:   r_mean  <= r_mean;
            endcase
        end
    end

    // end-time arithmetic ahead of the chain
    ffua_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_cmd   (i_cmd),
        .i_mean  (r_mean),
        .o_tok   (w_tok[0])
    );

    // one cell per unit
    for (genvar g = 0; g < UNITS; g++) begin : g_cell
        ffua_cell #(
            .CELL_ID (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_count (r_count),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign w_last = w_tok[UNITS];

    // result from the token leaving the chain
    always_comb begin
        n_rsp.status   = ST_OK;
        n_rsp.unit     = w_last.idx[UNIT_W-1:0];
        n_rsp.time_out = w_last.tout;
        if (w_last.op == OP_ALLOC) begin
            if (w_last.found) begin
                n_rsp.unit = w_last.unit;
            end else begin
                n_rsp.status = ST_NOFREE;
                n_rsp.unit   = '0;
            end
        end else if ({1'b0, w_last.idx} >= UNITS_X) begin
            n_rsp.status = ST_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_last.vld;
            if (w_load) begin
                r_busy <= 1'b1;
            end else if (w_last.vld) begin
                r_busy <= 1'b0;
            end
        end
        if (w_last.vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
`default_nettype wire
